// ----- rtl/rcddm_pkg.sv -----
// Shared types and constants for the differential drive mixer.
`timescale 1ns / 1ps

package rcddm_pkg;

   // Configuration register indexes
   localparam logic CSR_CENTER_US = 1'b0;
   localparam logic CSR_DEAD_BAND = 1'b1;

   localparam int CENTER_W    = 12;
   localparam int DEAD_BAND_W = 9;
   localparam int PULSE_W     = 15;
   localparam int PWM_W       = 8;
   localparam int SPEED_W     = 11;  // signed half-microsecond speed, -1000..1000
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CENTER_W-1:0]    CENTER_RESET    = 12'd1500;
   localparam logic [DEAD_BAND_W-1:0] DEAD_BAND_RESET = 9'd4;

   // Speed limit in half units
   localparam int HALF_LIMIT = 1000;

   // floor(s*255/500) == (s*267393) >> 19 exactly for s in 0..500
   localparam logic [18:0] PWM_RECIP = 19'd267393;
   localparam int          PWM_SHIFT = 19;

   typedef logic signed [SPEED_W-1:0] speed_type;

   typedef struct packed {
      logic             in1;
      logic             in2;
      logic [PWM_W-1:0] pwm;
   } side_type;

endpackage

// ----- rtl/rc_differential_drive_mixer_unit.sv -----
// Top level of the RC differential (arcade) drive mixer.
`timescale 1ns / 1ps

// Takes one request of two RC stick pulse widths (turn and drive, in us) and
// returns one response with H-bridge direction bits and an 8-bit PWM duty for
// the right and left motor sides. center_us is subtracted from both pulses;
// the turn term flips sign when the drive term is negative (zero drive counts
// as positive); right = fb - turn/2, left = fb + turn/2, clamped to +/-500 and
// held exactly in half-us units. A side with |speed| below dead_band stops
// (in1 = in2 = pwm = 0); otherwise pwm = trunc(|speed|)*255/500, truncated.
// A pulse of 0 (receiver timeout) is not special and reads as full negative.
// Rate: one request per cycle sustained while rsp_tready stays high. A request
// passes through two registers, the input register and the response register,
// before it shows on rsp_. Each register has its own ready, so a new request
// is taken while a finished response waits, as long as the input register is
// empty. Configuration writes via csr_ take effect at once and should only be
// made while no request is in flight.
module rc_differential_drive_mixer_unit
   import rcddm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: [14:0] turn_pulse_us, [29:15] drive_pulse_us, [31:30] zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // response: [0] right_in1, [1] right_in2, [9:2] right_pwm,
   //           [10] left_in1, [11] left_in2, [19:12] left_pwm, [23:20] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // configuration: index 0 center_us, index 1 dead_band
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CENTER_W-1:0]    csr_wdata
);

   logic [CENTER_W-1:0]    center_ff,    center_in;
   logic [DEAD_BAND_W-1:0] dead_band_ff, dead_band_in;

   logic                   s1_valid_ff,  s1_valid_in;
   logic [PULSE_W-1:0]     turn_ff,      turn_in;
   logic [PULSE_W-1:0]     drive_ff,     drive_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff,  rsp_data_in;

   logic out_en;
   logic s1_en;

   logic signed [17:0] lr;
   logic signed [17:0] fb;
   logic signed [17:0] turn_term;
   logic signed [19:0] right_raw;
   logic signed [19:0] left_raw;
   speed_type          right_speed;
   speed_type          left_speed;
   side_type           right_side;
   side_type           left_side;

   function automatic speed_type clamp_half(input logic signed [19:0] v);
      speed_type r;
      if (v > 20'sd1000) begin
         r = SPEED_W'(HALF_LIMIT);
      end else if (v < -20'sd1000) begin
         r = SPEED_W'(-HALF_LIMIT);
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

   // --- configuration registers ---
   always_comb begin
      center_in    = center_ff;
      dead_band_in = dead_band_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_US: center_in    = csr_wdata;
            CSR_DEAD_BAND: dead_band_in = csr_wdata[DEAD_BAND_W-1:0];
            default:       center_in    = center_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= CENTER_RESET;
         dead_band_ff <= DEAD_BAND_RESET;
      end else begin
         center_ff    <= center_in;
         dead_band_ff <= dead_band_in;
      end
   end

   // --- handshake: each stage loads when it is empty or draining ---
   assign out_en     = ~rsp_valid_ff | rsp_tready;
   assign s1_en      = ~s1_valid_ff | out_en;
   assign req_tready = s1_en;

   always_comb begin
      s1_valid_in  = s1_en  ? req_tvalid  : s1_valid_ff;
      turn_in      = (s1_en & req_tvalid) ? req_tdata[PULSE_W-1:0] : turn_ff;
      drive_in     = (s1_en & req_tvalid) ? req_tdata[2*PULSE_W-1:PULSE_W] : drive_ff;
      rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;
   end

   // --- mixer arithmetic between the two registers ---
   always_comb begin
      lr        = $signed({3'b000, turn_ff})  - $signed({6'b000000, center_ff});
      fb        = $signed({3'b000, drive_ff}) - $signed({6'b000000, center_ff});
      turn_term = fb[17] ? -lr : lr;
      // speeds in half-us units: 2*fb -/+ turn
      right_raw = 20'(fb) * 20'sd2 - 20'(turn_term);
      left_raw  = 20'(fb) * 20'sd2 + 20'(turn_term);
      right_speed = clamp_half(right_raw);
      left_speed  = clamp_half(left_raw);
   end

   rcddm_side u_right (
      .speed_half (right_speed),
      .dead_band  (dead_band_ff),
      .side       (right_side)
   );

   rcddm_side u_left (
      .speed_half (left_speed),
      .dead_band  (dead_band_ff),
      .side       (left_side)
   );

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (out_en & s1_valid_ff) begin
         rsp_data_in = {4'b0000,
                        left_side.pwm,  left_side.in2,  left_side.in1,
                        right_side.pwm, right_side.in2, right_side.in1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      turn_ff     <= turn_in;
      drive_ff    <= drive_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/rcddm_side.sv -----
// One motor side: dead band test, bridge direction and PWM duty from a speed.
`timescale 1ns / 1ps

module rcddm_side
   import rcddm_pkg::*;
(
   input  speed_type              speed_half,
   input  logic [DEAD_BAND_W-1:0] dead_band,
   output side_type               side
);

   speed_type          neg;
   logic [SPEED_W-2:0] mag;
   logic [SPEED_W-2:0] db2;
   logic [SPEED_W-3:0] speed_us;
   logic [27:0]        prod;
   logic               stop;

   always_comb begin
      neg      = -speed_half;
      mag      = speed_half[SPEED_W-1] ? neg[SPEED_W-2:0] : speed_half[SPEED_W-2:0];
      db2      = {dead_band, 1'b0};
      stop     = (mag < db2);
      speed_us = mag[SPEED_W-2:1];
      prod     = 28'(speed_us) * 28'(PWM_RECIP);
      if (stop) begin
         side = '0;
      end else begin
         // exactly +dead band and a zero speed both count as forward
         side.in1 = ~speed_half[SPEED_W-1];
         side.in2 = speed_half[SPEED_W-1];
         side.pwm = prod[PWM_SHIFT +: PWM_W];
      end
   end

endmodule

// ----- rtl/rcddm_checker.sv -----
// Port-level assertions for the drive mixer, bound to the top level.
`timescale 1ns / 1ps

module rcddm_checker
   import rcddm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // nothing left over after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a bridge is never driven both ways
   a_dir_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]) && !(rsp_tdata[10] && rsp_tdata[11]))
      else $error("bridge driven forward and backward at once");

   // a stopped side has no duty
   a_stop_pwm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[1] || rsp_tdata[9:2] == 8'd0) &&
                     (rsp_tdata[10] || rsp_tdata[11] || rsp_tdata[19:12] == 8'd0))
      else $error("stopped side with nonzero PWM");

endmodule

bind rc_differential_drive_mixer_unit rcddm_checker u_rcddm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the differential drive mixer: directed table plus random requests.
`timescale 1ns / 1ps

module tb_top;
   import rcddm_pkg::*;

   // Full-scale duty and speed used by the duty mapping
   localparam int PWM_MAX     = 255;
   localparam int SPEED_MAX   = 500;
   localparam int PULSE_MAX   = 32767;
   localparam int CYCLE_LIMIT = 500000;
   localparam int N_PHASES    = 6;
   localparam int PHASE_ITEMS = 160;

   // One response: right side in the upper half, left side in the lower
   typedef struct packed {
      side_type right;
      side_type left;
   } drive_pair;

   // One row of the directed table: register setting, the request and,
   // where it is obvious, the expected response typed in by hand
   typedef struct {
      logic [CENTER_W-1:0]    center;
      logic [DEAD_BAND_W-1:0] band;
      logic [PULSE_W-1:0]     turn;
      logic [PULSE_W-1:0]     drive;
      bit                     typed;
      drive_pair              want;
   } stim_row;

   localparam side_type STOPPED   = '0;
   localparam side_type FWD_FULL  = {1'b1, 1'b0, 8'd255};
   localparam side_type BACK_FULL = {1'b0, 1'b1, 8'd255};
   localparam side_type FWD_ZERO  = {1'b1, 1'b0, 8'd0};
   localparam side_type BACK_ZERO = {1'b0, 1'b1, 8'd0};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = CSR_CENTER_US;
   logic [CENTER_W-1:0]   csr_wdata  = '0;

   // Shadow copy of the block's registers, used by the predictor
   logic [CENTER_W-1:0]    center_cfg = CENTER_RESET;
   logic [DEAD_BAND_W-1:0] band_cfg   = DEAD_BAND_RESET;

   drive_pair pending_q[$];    // expected responses, oldest first
   stim_row   dir_table[$];
   drive_pair got_pair;
   drive_pair want_pair;
   int        error_count = 0;
   int        cycle_count = 0;
   int        rx_count    = 0;
   int        burst_left  = 0;

   rc_differential_drive_mixer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // One motor side from a speed in half-microsecond units
   function automatic side_type side_from_speed(int h, int band);
      int       mag;
      int       db2;
      side_type s;
      mag = (h < 0) ? -h : h;
      db2 = 2 * band;
      s   = STOPPED;
      // below the dead band the bridge is released; exactly at it, drive
      if (mag >= db2) begin
         s.pwm = 8'(((mag >> 1) * PWM_MAX) / SPEED_MAX);
         s.in1 = (h >= db2);
         s.in2 = !(h >= db2);
      end
      return s;
   endfunction

   function automatic int clamp_speed(int v);
      if (v > HALF_LIMIT) return HALF_LIMIT;
      if (v < -HALF_LIMIT) return -HALF_LIMIT;
      return v;
   endfunction

   // Arcade mix: turn term flips with reverse drive, zero drive counts forward.
   // Speeds stay in half units so the /2 on the turn term is exact.
   function automatic drive_pair mix_predict(logic [PULSE_W-1:0] turn,
                                             logic [PULSE_W-1:0] drive);
      int        lr;
      int        fb;
      int        steer;
      drive_pair p;
      lr      = int'(turn) - int'(center_cfg);
      fb      = int'(drive) - int'(center_cfg);
      steer   = (fb >= 0) ? lr : -lr;
      p.right = side_from_speed(clamp_speed(2 * fb - steer), int'(band_cfg));
      p.left  = side_from_speed(clamp_speed(2 * fb + steer), int'(band_cfg));
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Send one request; the sender runs in bursts with random gaps between.
   // valid is only dropped here when a gap starts, never between back-to-back
   // requests, so it never sees two assignments in one step.
   task automatic push_request(input logic [PULSE_W-1:0] turn,
                               input logic [PULSE_W-1:0] drive,
                               input bit typed, input drive_pair want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, drive, turn};
      do @(posedge clock); while (!req_tready);
      pending_q.push_back(typed ? want : mix_predict(turn, drive));
      burst_left--;
   endtask

   // Registers change only with the pipe empty
   task automatic apply_setting(input logic [CENTER_W-1:0] center,
                                input logic [CENTER_W-1:0] band_word);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CENTER_US;
      csr_wdata <= center;
      @(posedge clock);
      csr_index <= CSR_DEAD_BAND;
      csr_wdata <= band_word;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      center_cfg = center;
      band_cfg   = band_word[DEAD_BAND_W-1:0];
   endtask

   task automatic add_row(input int center, input int band, input int turn,
                          input int drive, input bit typed, input drive_pair want);
      stim_row r;
      r.center = CENTER_W'(center);
      r.band   = DEAD_BAND_W'(band);
      r.turn   = PULSE_W'(turn);
      r.drive  = PULSE_W'(drive);
      r.typed  = typed;
      r.want   = want;
      dir_table.push_back(r);
   endtask

   // Random pulse: mostly near the neutral point, with timeouts, exact
   // neutral, full-range values and dead-band edges mixed in
   function automatic logic [PULSE_W-1:0] pick_pulse(int mid, int band);
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      if (sel < 55)      v = mid + $urandom_range(0, 1300) - 650;
      else if (sel < 65) v = mid;
      else if (sel < 75) v = mid + (($urandom_range(0, 1) != 0) ? band : -band)
                             + $urandom_range(0, 2) - 1;
      else if (sel < 82) v = 0;
      else if (sel < 94) v = $urandom_range(0, PULSE_MAX);
      else               v = $urandom_range(0, 25000);
      if (v < 0) v = 0;
      if (v > PULSE_MAX) v = PULSE_MAX;
      return PULSE_W'(v);
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [CENTER_W-1:0] center;
      logic [CENTER_W-1:0] band_word;
      logic [PULSE_W-1:0]  turn;
      logic [PULSE_W-1:0]  drive;
      int                  e;

      //        center band  turn   drive  typed  {right, left}
      add_row(1500,  4,  1500,  1500, 1, {STOPPED, STOPPED});     // neutral
      add_row(1500,  4,     0,     0, 1, {BACK_FULL, BACK_FULL}); // both timed out
      add_row(1500,  4, 25000, 25000, 1, {FWD_FULL, FWD_FULL});
      add_row(1500,  4, 32767, 32767, 1, {FWD_FULL, FWD_FULL});   // field max
      add_row(1500,  4,  1500,  2000, 1, {FWD_FULL, FWD_FULL});   // full forward
      add_row(1500,  4,  1500,  1000, 1, {BACK_FULL, BACK_FULL}); // full reverse
      add_row(1500,  4,  1500,  1504, 1,
              {side_type'({1'b1, 1'b0, 8'd2}), side_type'({1'b1, 1'b0, 8'd2})});
      add_row(1500,  4,  1500,  1496, 1,
              {side_type'({1'b0, 1'b1, 8'd2}), side_type'({1'b0, 1'b1, 8'd2})});
      add_row(1500,  4,  1500,  1503, 1, {STOPPED, STOPPED});     // just inside band
      add_row(1500,  4,  2000,  1500, 0, '0);                     // spin, zero drive
      add_row(1500,  4,  2000,  1400, 0, '0);                     // turn while reversing
      add_row(1500,  4,  1501,  1500, 0, '0);                     // half-unit speeds
      add_row(1500,  0,  1500,  1500, 1, {FWD_ZERO, FWD_ZERO});   // no band: never stops
      add_row(1500,  0,  1501,  1500, 1, {BACK_ZERO, FWD_ZERO});
      add_row(1500,511,  1500,  2000, 1, {STOPPED, STOPPED});     // band above full speed
      add_row(1500,500,  1500,  2000, 1, {FWD_FULL, FWD_FULL});   // band at full speed
      add_row(   0,  4,     0,     0, 1, {STOPPED, STOPPED});
      add_row(   0,  4,     0, 32767, 1, {FWD_FULL, FWD_FULL});
      add_row(4095,  4,     0,     0, 1, {BACK_FULL, BACK_FULL});
      add_row(4095,  4, 32767, 32767, 1, {FWD_FULL, FWD_FULL});
      add_row(4095,  4,     0,  4095, 0, '0);
      add_row(1500,  4,  1300,  1700, 0, '0);
      add_row(1500,  4, 21845, 10922, 0, '0);                     // alternating bits

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; registers follow each row's setting
      foreach (dir_table[i]) begin
         if (dir_table[i].center != center_cfg || dir_table[i].band != band_cfg)
            apply_setting(dir_table[i].center, CENTER_W'(dir_table[i].band));
         push_request(dir_table[i].turn, dir_table[i].drive,
                      dir_table[i].typed, dir_table[i].want);
      end

      // Random phases: reset values, both extremes, band at full speed, then random settings
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: begin
               center    = CENTER_RESET;
               band_word = CENTER_W'(DEAD_BAND_RESET);
            end
            1: begin
               center    = '0;
               band_word = '0;
            end
            2: begin
               center    = '1;
               band_word = CENTER_W'(511);
            end
            3: begin
               center    = 12'd1500;
               band_word = CENTER_W'(SPEED_MAX);
            end
            4: begin
               center    = CENTER_W'($urandom_range(1000, 2000));
               band_word = CENTER_W'($urandom_range(0, 60));
            end
            default: begin
               // upper write-data bits are not part of the band register
               center    = CENTER_W'($urandom_range(0, 4095));
               band_word = {3'($urandom_range(0, 7)), 9'($urandom_range(0, 511))};
            end
         endcase
         apply_setting(center, band_word);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               // right on the dead-band edge, no turn
               e     = int'(center_cfg) + (($urandom_range(0, 1) != 0) ?
                       int'(band_cfg) : -int'(band_cfg)) + $urandom_range(0, 2) - 1;
               turn  = PULSE_W'(center_cfg);
               drive = PULSE_W'((e < 0) ? 0 : e);
            end else begin
               turn  = pick_pulse(int'(center_cfg), int'(band_cfg));
               drive = pick_pulse(int'(center_cfg), int'(band_cfg));
            end
            push_request(turn, drive, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: checker and stall pattern
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: response with no request pending, expected none actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want_pair           = pending_q.pop_front();
            got_pair.right.in1  = rsp_tdata[0];
            got_pair.right.in2  = rsp_tdata[1];
            got_pair.right.pwm  = rsp_tdata[9:2];
            got_pair.left.in1   = rsp_tdata[10];
            got_pair.left.in2   = rsp_tdata[11];
            got_pair.left.pwm   = rsp_tdata[19:12];
            check_field("right_in1", int'(want_pair.right.in1), int'(got_pair.right.in1));
            check_field("right_in2", int'(want_pair.right.in2), int'(got_pair.right.in2));
            check_field("right_pwm", int'(want_pair.right.pwm), int'(got_pair.right.pwm));
            check_field("left_in1", int'(want_pair.left.in1), int'(got_pair.left.in1));
            check_field("left_in2", int'(want_pair.left.in2), int'(got_pair.left.in2));
            check_field("left_pwm", int'(want_pair.left.pwm), int'(got_pair.left.pwm));
         end
      end
      // stall pattern cycles through: always ready, short periodic stalls,
      // coin flips, and long stalls that back up the pipe
      rx_count = rx_count + 1;
      case ((rx_count >> 9) & 3)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ((rx_count & 7) != 0);
         2:       rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= ((rx_count & 31) >= 20);
      endcase
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
